FILE: rtl/assert_macros.svh
// Assertion helpers included by the execute unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/exu_pkg.sv
package exu_pkg;

  // Major opcodes
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;

  // funct7 value that selects the multiply/divide group
  localparam logic [6:0] F7_MULDIV  = 7'h01;

  // ALU funct3 codes
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SRL  = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // Multiply funct3 codes
  localparam logic [2:0] F3_MUL    = 3'd0;
  localparam logic [2:0] F3_MULH   = 3'd1;
  localparam logic [2:0] F3_MULHSU = 3'd2;
  localparam logic [2:0] F3_MULHU  = 3'd3;

  // Branch funct3 codes
  localparam logic [2:0] BR_EQ  = 3'd0;
  localparam logic [2:0] BR_NE  = 3'd1;
  localparam logic [2:0] BR_LT  = 3'd4;
  localparam logic [2:0] BR_GE  = 3'd5;
  localparam logic [2:0] BR_LTU = 3'd6;
  localparam logic [2:0] BR_GEU = 3'd7;

  localparam logic [31:0] JALR_MASK = 32'hFFFF_FFFE;
  localparam logic [31:0] LINK_STEP = 32'd4;

  // Width of a sign-extended multiplier operand
  localparam int MUL_OP_W = 33;

  // Per-instruction control flags carried down the pipeline
  typedef struct packed {
    logic take_jump;
    logic write_back;
    logic unsupported;
    logic is_mul;
    logic mul_hi;
  } ctrl_t;

endpackage

FILE: rtl/rv32im_execute_unit.sv
// RV32IM execute unit: three register stages (input capture, ALU/branch decode,
// multiply and final select). A transaction moves through the capture, decode
// and output registers in order, and a new one can be accepted each cycle
// while the output is not stalled; the 33x33-bit signed multiplier in the last
// stage sets the clock-period limit. Each stage advances on its own when empty
// or when the next stage can take its contents, so bubbles are squeezed out
// under backpressure. No state survives between transactions.
`include "assert_macros.svh"

module rv32im_execute_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [6:0]         cmd,
  input  logic [2:0]         funct3,
  input  logic [6:0]         funct7,
  input  logic [31:0]        pc,
  input  logic signed [31:0] rs1_value,
  input  logic signed [31:0] rs2_value,
  input  logic signed [31:0] imm,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] result,
  output logic [31:0]        target_address,
  output logic               take_jump,
  output logic               write_back,
  output logic signed [31:0] store_data,
  output logic               unsupported
);

  localparam int MW = exu_pkg::MUL_OP_W;

  // Stage 1: captured instruction
  logic        s1_valid;
  logic [6:0]  s1_cmd;
  logic [2:0]  s1_funct3;
  logic [6:0]  s1_funct7;
  logic [31:0] s1_pc;
  logic [31:0] s1_a;
  logic [31:0] s1_b;
  logic [31:0] s1_imm;

  // Stage 2: decoded results and multiplier operands
  logic           s2_valid;
  logic [31:0]    s2_alu;
  logic [31:0]    s2_target;
  logic [31:0]    s2_sdata;
  logic [MW-1:0]  s2_mul_a;
  logic [MW-1:0]  s2_mul_b;
  exu_pkg::ctrl_t s2_ctrl;

  // Combinational outputs of the decode stage
  logic [31:0]    alu_res;
  logic [31:0]    alu_target;
  logic [31:0]    alu_sdata;
  logic [MW-1:0]  alu_mul_a;
  logic [MW-1:0]  alu_mul_b;
  exu_pkg::ctrl_t alu_ctrl;

  logic signed [2*MW-1:0] product;
  logic [31:0]            result_next;

  logic s1_ready;
  logic s2_ready;
  logic s3_ready;

  assign s3_ready = !out_valid || out_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  // Capture the incoming transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
    if (s1_ready && in_valid) begin
      s1_cmd    <= cmd;
      s1_funct3 <= funct3;
      s1_funct7 <= funct7;
      s1_pc     <= pc;
      s1_a      <= rs1_value;
      s1_b      <= rs2_value;
      s1_imm    <= imm;
    end
  end

  exu_alu u_alu (
    .cmd     (s1_cmd),
    .funct3  (s1_funct3),
    .funct7  (s1_funct7),
    .pc      (s1_pc),
    .opa     (s1_a),
    .opb     (s1_b),
    .imm     (s1_imm),
    .alu_res (alu_res),
    .target  (alu_target),
    .sdata   (alu_sdata),
    .mul_a   (alu_mul_a),
    .mul_b   (alu_mul_b),
    .ctrl    (alu_ctrl)
  );

  // Advance decoded results into stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
    if (s2_ready && s1_valid) begin
      s2_alu    <= alu_res;
      s2_target <= alu_target;
      s2_sdata  <= alu_sdata;
      s2_mul_a  <= alu_mul_a;
      s2_mul_b  <= alu_mul_b;
      s2_ctrl   <= alu_ctrl;
    end
  end

  // Multiply and pick the final value
  assign product = $signed(s2_mul_a) * $signed(s2_mul_b);

  always_comb begin
    if (s2_ctrl.is_mul) begin
      result_next = s2_ctrl.mul_hi ? product[63:32] : product[31:0];
    end else begin
      result_next = s2_alu;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_ready) begin
      out_valid <= s2_valid;
    end
    if (s3_ready && s2_valid) begin
      result         <= result_next;
      target_address <= s2_target;
      take_jump      <= s2_ctrl.take_jump;
      write_back     <= s2_ctrl.write_back;
      store_data     <= s2_sdata;
      unsupported    <= s2_ctrl.unsupported;
    end
  end

  // A stalled stage keeps its transaction
  `ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !s2_ready, s1_valid)
  `ASSERT_NEXT(a_s2_hold, clk, rst, s2_valid && !s3_ready, s2_valid)
  // Unknown opcodes never redirect, always write back a zero
  `ASSERT_IMPLY(a_unsup, clk, rst, out_valid && unsupported,
                !take_jump && write_back && (result == 32'sd0))
  // Only stores carry store data, and they never write back
  `ASSERT_IMPLY(a_store, clk, rst, out_valid && (store_data != 32'sd0), !write_back)
  // Multiplies are always supported register writes without a jump
  `ASSERT_IMPLY(a_mul, clk, rst, s2_valid && s2_ctrl.is_mul,
                s2_ctrl.write_back && !s2_ctrl.unsupported && !s2_ctrl.take_jump)

endmodule

FILE: rtl/exu_alu.sv
module exu_alu (
  input  logic [6:0]  cmd,
  input  logic [2:0]  funct3,
  input  logic [6:0]  funct7,
  input  logic [31:0] pc,
  input  logic [31:0] opa,
  input  logic [31:0] opb,
  input  logic [31:0] imm,
  output logic [31:0] alu_res,
  output logic [31:0] target,
  output logic [31:0] sdata,
  output logic [exu_pkg::MUL_OP_W-1:0] mul_a,
  output logic [exu_pkg::MUL_OP_W-1:0] mul_b,
  output exu_pkg::ctrl_t ctrl
);

  function automatic logic lt_signed(input logic [31:0] x, input logic [31:0] y);
    return $signed(x) < $signed(y);
  endfunction

  function automatic logic [31:0] alu_op(input logic [2:0] f3, input logic alt,
                                         input logic [31:0] x, input logic [31:0] y);
    logic [4:0]  sh;
    logic [31:0] r;
    sh = y[4:0];
    case (f3)
      exu_pkg::F3_ADD:  r = alt ? x - y : x + y;
      exu_pkg::F3_SLL:  r = x << sh;
      exu_pkg::F3_SLT:  r = {31'd0, lt_signed(x, y)};
      exu_pkg::F3_SLTU: r = {31'd0, (x < y)};
      exu_pkg::F3_XOR:  r = x ^ y;
      exu_pkg::F3_SRL:  r = alt ? 32'($signed(x) >>> sh) : x >> sh;
      exu_pkg::F3_OR:   r = x | y;
      default:          r = x & y;
    endcase
    return r;
  endfunction

  function automatic logic branch_cond(input logic [2:0] f3, input logic [31:0] x,
                                       input logic [31:0] y);
    logic c;
    case (f3)
      exu_pkg::BR_EQ:  c = (x == y);
      exu_pkg::BR_NE:  c = (x != y);
      exu_pkg::BR_LT:  c = lt_signed(x, y);
      exu_pkg::BR_GE:  c = !lt_signed(x, y);
      exu_pkg::BR_LTU: c = (x < y);
      exu_pkg::BR_GEU: c = (x >= y);
      default:         c = 1'b0;
    endcase
    return c;
  endfunction

  logic        alt;
  logic [2:0]  mf;
  logic        sa;
  logic        sb;
  logic        cond;
  logic [31:0] pc_imm;
  logic [31:0] a_imm;

  assign alt    = funct7[5];
  assign pc_imm = pc + imm;
  assign a_imm  = opa + imm;
  assign cond   = branch_cond(funct3, opa, opb);

  // Divide codes fold onto the signed high product
  assign mf = funct3[2] ? exu_pkg::F3_MULH : funct3;
  assign sa = (mf != exu_pkg::F3_MULHU);
  assign sb = (mf != exu_pkg::F3_MULHSU) && (mf != exu_pkg::F3_MULHU);
  assign mul_a = {sa & opa[31], opa};
  assign mul_b = {sb & opb[31], opb};

  // Decode the opcode and pick the ALU value, target and flags
  always_comb begin
    alu_res          = '0;
    target           = '0;
    sdata            = '0;
    ctrl.take_jump   = 1'b0;
    ctrl.write_back  = 1'b1;
    ctrl.unsupported = 1'b0;
    ctrl.is_mul      = 1'b0;
    ctrl.mul_hi      = (mf != exu_pkg::F3_MUL);
    unique case (cmd)
      exu_pkg::OPC_LUI: begin
        alu_res = imm;
      end
      exu_pkg::OPC_AUIPC: begin
        alu_res = pc_imm;
      end
      exu_pkg::OPC_JAL: begin
        alu_res        = pc + exu_pkg::LINK_STEP;
        target         = pc_imm;
        ctrl.take_jump = 1'b1;
      end
      exu_pkg::OPC_JALR: begin
        alu_res        = pc + exu_pkg::LINK_STEP;
        target         = a_imm & exu_pkg::JALR_MASK;
        ctrl.take_jump = 1'b1;
      end
      exu_pkg::OPC_BRANCH: begin
        alu_res         = {31'd0, cond};
        target          = pc_imm;
        ctrl.take_jump  = cond;
        ctrl.write_back = 1'b0;
      end
      exu_pkg::OPC_LOAD: begin
        alu_res = a_imm;
      end
      exu_pkg::OPC_STORE: begin
        alu_res         = a_imm;
        sdata           = opb;
        ctrl.write_back = 1'b0;
      end
      exu_pkg::OPC_OPIMM: begin
        if (funct3 == exu_pkg::F3_ADD) begin
          alu_res = a_imm;
        end else begin
          alu_res = alu_op(funct3, (funct3 == exu_pkg::F3_SRL) && alt, opa, imm);
        end
      end
      exu_pkg::OPC_OP: begin
        if (funct7 == exu_pkg::F7_MULDIV) begin
          ctrl.is_mul = 1'b1;
        end else begin
          alu_res = alu_op(funct3, alt, opa, opb);
        end
      end
      default: begin
        ctrl.unsupported = 1'b1;
      end
    endcase
  end

endmodule
